[rtl/a2i_pkg.sv]
// Shared types and constants for the 2D affine inverse pipeline.
`default_nettype none

package a2i_pkg;

   localparam int NLANE = 6;

   // One divider lane for each result value.
   typedef enum logic [2:0] {
      LANE_XX,
      LANE_XY,
      LANE_YX,
      LANE_YY,
      LANE_OX,
      LANE_OY
   } lane_type;

   // Control bits that travel alongside the divider data.
   typedef struct packed {
      logic             valid;
      logic             sing;
      logic [NLANE-1:0] neg;
      logic [NLANE-1:0] ovf;
   } a2i_ctl_type;

endpackage

`default_nettype wire

[rtl/a2i_intf.sv]
// Valid/ready channel interfaces for transforms in and inverses out.
`default_nettype none

interface a2i_req_intf #(parameter int DATA_WIDTH = 32);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] in_xx;
   logic signed [DATA_WIDTH-1:0] in_xy;
   logic signed [DATA_WIDTH-1:0] in_yx;
   logic signed [DATA_WIDTH-1:0] in_yy;
   logic signed [DATA_WIDTH-1:0] in_ox;
   logic signed [DATA_WIDTH-1:0] in_oy;

   modport source (output valid, in_xx, in_xy, in_yx, in_yy, in_ox, in_oy, input ready);
   modport sink   (input valid, in_xx, in_xy, in_yx, in_yy, in_ox, in_oy, output ready);
endinterface

interface a2i_rsp_intf #(parameter int DATA_WIDTH = 32);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] out_xx;
   logic signed [DATA_WIDTH-1:0] out_xy;
   logic signed [DATA_WIDTH-1:0] out_yx;
   logic signed [DATA_WIDTH-1:0] out_yy;
   logic signed [DATA_WIDTH-1:0] out_ox;
   logic signed [DATA_WIDTH-1:0] out_oy;
   logic                         singular;
   logic                         saturated;

   modport source (output valid, out_xx, out_xy, out_yx, out_yy, out_ox, out_oy,
                   singular, saturated, input ready);
   modport sink   (input valid, out_xx, out_xy, out_yx, out_yy, out_ox, out_oy,
                   singular, saturated, output ready);
endinterface

`default_nettype wire

[rtl/a2i_front.sv]
// Front end: input register, products, determinant and numerators, divider set-up.
`default_nettype none

module a2i_front
   import a2i_pkg::*;
#(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16,
   parameter int DW         = 2 * DATA_WIDTH,
   parameter int NW         = 2 * DATA_WIDTH + FRAC_BITS
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         en,
   input  wire logic                         vld_i,
   input  wire logic signed [DATA_WIDTH-1:0] xx_i,
   input  wire logic signed [DATA_WIDTH-1:0] xy_i,
   input  wire logic signed [DATA_WIDTH-1:0] yx_i,
   input  wire logic signed [DATA_WIDTH-1:0] yy_i,
   input  wire logic signed [DATA_WIDTH-1:0] ox_i,
   input  wire logic signed [DATA_WIDTH-1:0] oy_i,
   output      a2i_ctl_type                  ctl_o,
   output      logic [DW-1:0]                den_o,
   output      logic [DW-1:0]                rem_o [NLANE],
   output      logic [DATA_WIDTH-1:0]        low_o [NLANE]
);

   localparam int W  = DATA_WIDTH;
   localparam int HW = NW - W;
   localparam int CW = (HW > DW) ? HW : DW;

   // stage A: inputs
   logic                 va_ff;
   logic signed [W-1:0]  a_ff, b_ff, c_ff, d_ff, ox_ff, oy_ff;
   // stage B: products
   logic                 vb_ff;
   logic signed [W-1:0]  bb_a_ff, bb_b_ff, bb_c_ff, bb_d_ff;
   logic signed [2*W-1:0] p_ad_ff, p_bc_ff, p_coy_ff, p_dox_ff, p_box_ff, p_aoy_ff;
   // stage C: magnitudes
   logic                 vc_ff;
   logic                 sing_ff, dneg_ff;
   logic [DW-1:0]        dmag_ff;
   logic [NW-1:0]        num_ff [NLANE];
   logic [NLANE-1:0]     nneg_ff;
   // stage D: divider set-up
   a2i_ctl_type          ctl_ff;
   logic [DW-1:0]        den_ff;
   logic [DW-1:0]        rem_ff [NLANE];
   logic [W-1:0]         low_ff [NLANE];

   logic signed [2*W:0]  det_in, t1_in, t2_in;
   logic [DW-1:0]        dmag_in, t1m_in, t2m_in;
   logic [W-1:0]         am_in, bm_in, cm_in, dm_in;
   logic [NW-1:0]        num_in [NLANE];
   logic [NLANE-1:0]     nneg_in;
   logic [NLANE-1:0]     ovf_in;
   logic [DW-1:0]        rem_in [NLANE];
   logic [W-1:0]         low_in [NLANE];

   always_comb begin
      det_in = (2*W+1)'(p_ad_ff) - (2*W+1)'(p_bc_ff);
      t1_in  = (2*W+1)'(p_coy_ff) - (2*W+1)'(p_dox_ff);
      t2_in  = (2*W+1)'(p_box_ff) - (2*W+1)'(p_aoy_ff);
      dmag_in = det_in[2*W] ? DW'(-det_in) : DW'(det_in);
      t1m_in  = t1_in[2*W] ? DW'(-t1_in) : DW'(t1_in);
      t2m_in  = t2_in[2*W] ? DW'(-t2_in) : DW'(t2_in);
      am_in = bb_a_ff[W-1] ? W'(-bb_a_ff) : W'(bb_a_ff);
      bm_in = bb_b_ff[W-1] ? W'(-bb_b_ff) : W'(bb_b_ff);
      cm_in = bb_c_ff[W-1] ? W'(-bb_c_ff) : W'(bb_c_ff);
      dm_in = bb_d_ff[W-1] ? W'(-bb_d_ff) : W'(bb_d_ff);
      num_in[LANE_XX] = NW'(dm_in) << (2 * FRAC_BITS);
      num_in[LANE_XY] = NW'(bm_in) << (2 * FRAC_BITS);
      num_in[LANE_YX] = NW'(cm_in) << (2 * FRAC_BITS);
      num_in[LANE_YY] = NW'(am_in) << (2 * FRAC_BITS);
      num_in[LANE_OX] = NW'(t1m_in) << FRAC_BITS;
      num_in[LANE_OY] = NW'(t2m_in) << FRAC_BITS;
      // off-diagonal terms carry an extra minus sign
      nneg_in[LANE_XX] = bb_d_ff[W-1];
      nneg_in[LANE_XY] = ~bb_b_ff[W-1];
      nneg_in[LANE_YX] = ~bb_c_ff[W-1];
      nneg_in[LANE_YY] = bb_a_ff[W-1];
      nneg_in[LANE_OX] = t1_in[2*W];
      nneg_in[LANE_OY] = t2_in[2*W];
   end

   // high part of numerator against divisor: at or above it the quotient will not fit
   always_comb begin
      for (int l = 0; l < NLANE; l++) begin
         ovf_in[l] = CW'(num_ff[l][NW-1:W]) >= CW'(dmag_ff);
         rem_in[l] = ovf_in[l] ? '0 : DW'(num_ff[l][NW-1:W]);
         low_in[l] = num_ff[l][W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff        <= 1'b0;
         vb_ff        <= 1'b0;
         vc_ff        <= 1'b0;
         ctl_ff.valid <= 1'b0;
      end else if (en) begin
         va_ff        <= vld_i;
         vb_ff        <= va_ff;
         vc_ff        <= vb_ff;
         ctl_ff.valid <= vc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff  <= xx_i;
         b_ff  <= xy_i;
         c_ff  <= yx_i;
         d_ff  <= yy_i;
         ox_ff <= ox_i;
         oy_ff <= oy_i;
         bb_a_ff  <= a_ff;
         bb_b_ff  <= b_ff;
         bb_c_ff  <= c_ff;
         bb_d_ff  <= d_ff;
         p_ad_ff  <= a_ff * d_ff;
         p_bc_ff  <= b_ff * c_ff;
         p_coy_ff <= c_ff * oy_ff;
         p_dox_ff <= d_ff * ox_ff;
         p_box_ff <= b_ff * ox_ff;
         p_aoy_ff <= a_ff * oy_ff;
         sing_ff <= (det_in == '0);
         dneg_ff <= det_in[2*W];
         dmag_ff <= dmag_in;
         nneg_ff <= nneg_in;
         for (int l = 0; l < NLANE; l++) begin
            num_ff[l] <= num_in[l];
         end
         ctl_ff.sing <= sing_ff;
         ctl_ff.neg  <= nneg_ff ^ {NLANE{dneg_ff}};
         ctl_ff.ovf  <= ovf_in;
         den_ff      <= dmag_ff;
         for (int l = 0; l < NLANE; l++) begin
            rem_ff[l] <= rem_in[l];
            low_ff[l] <= low_in[l];
         end
      end
   end

   assign ctl_o = ctl_ff;
   assign den_o = den_ff;
   assign rem_o = rem_ff;
   assign low_o = low_ff;

endmodule

`default_nettype wire

[rtl/a2i_div_step.sv]
// One restoring-division step, one quotient bit for each of the six lanes.
`default_nettype none

module a2i_div_step
   import a2i_pkg::*;
#(
   parameter int DATA_WIDTH = 32,
   parameter int DW         = 2 * DATA_WIDTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  en,
   input  wire a2i_ctl_type           ctl_i,
   input  wire logic [DW-1:0]         den_i,
   input  wire logic [DW-1:0]         rem_i [NLANE],
   input  wire logic [DATA_WIDTH-1:0] low_i [NLANE],
   input  wire logic [DATA_WIDTH-1:0] q_i   [NLANE],
   output      a2i_ctl_type           ctl_o,
   output      logic [DW-1:0]         den_o,
   output      logic [DW-1:0]         rem_o [NLANE],
   output      logic [DATA_WIDTH-1:0] low_o [NLANE],
   output      logic [DATA_WIDTH-1:0] q_o   [NLANE]
);

   localparam int W = DATA_WIDTH;

   a2i_ctl_type   ctl_ff;
   logic [DW-1:0] den_ff;
   logic [DW-1:0] rem_ff [NLANE];
   logic [W-1:0]  low_ff [NLANE];
   logic [W-1:0]  q_ff   [NLANE];

   logic [DW:0]   t_in  [NLANE];
   logic [DW:0]   d_in  [NLANE];
   logic          ge_in [NLANE];

   always_comb begin
      for (int l = 0; l < NLANE; l++) begin
         t_in[l]  = {rem_i[l], low_i[l][W-1]};
         d_in[l]  = t_in[l] - (DW+1)'(den_i);
         ge_in[l] = t_in[l] >= (DW+1)'(den_i);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (en) begin
         ctl_ff.valid <= ctl_i.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctl_ff.sing <= ctl_i.sing;
         ctl_ff.neg  <= ctl_i.neg;
         ctl_ff.ovf  <= ctl_i.ovf;
         den_ff      <= den_i;
         for (int l = 0; l < NLANE; l++) begin
            rem_ff[l] <= ge_in[l] ? DW'(d_in[l]) : DW'(t_in[l]);
            low_ff[l] <= low_i[l] << 1;
            q_ff[l]   <= {q_i[l][W-2:0], ge_in[l]};
         end
      end
   end

   assign ctl_o = ctl_ff;
   assign den_o = den_ff;
   assign rem_o = rem_ff;
   assign low_o = low_ff;
   assign q_o   = q_ff;

endmodule

`default_nettype wire

[rtl/a2i_back.sv]
// Back end: sign, saturation and singular handling into the output register.
`default_nettype none

module a2i_back
   import a2i_pkg::*;
#(
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  en,
   input  wire a2i_ctl_type           ctl_i,
   input  wire logic [DATA_WIDTH-1:0] q_i [NLANE],
   output      logic                  vld_o,
   output      logic [DATA_WIDTH-1:0] val_o [NLANE],
   output      logic                  sing_o,
   output      logic                  sat_o
);

   localparam int W = DATA_WIDTH;

   logic             vld_ff, sing_ff, sat_ff;
   logic [W-1:0]     val_ff [NLANE];

   logic [W-1:0]     lim_in [NLANE];
   logic [W-1:0]     mag_in [NLANE];
   logic [W-1:0]     val_in [NLANE];
   logic [NLANE-1:0] sat_in;

   always_comb begin
      for (int l = 0; l < NLANE; l++) begin
         lim_in[l] = ctl_i.neg[l] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
         sat_in[l] = ~ctl_i.sing & (ctl_i.ovf[l] | (q_i[l] > lim_in[l]));
         mag_in[l] = sat_in[l] ? lim_in[l] : q_i[l];
         if (ctl_i.sing) begin
            val_in[l] = '0;
         end else begin
            val_in[l] = ctl_i.neg[l] ? W'(-mag_in[l]) : mag_in[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= ctl_i.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sing_ff <= ctl_i.sing;
         sat_ff  <= |sat_in;
         for (int l = 0; l < NLANE; l++) begin
            val_ff[l] <= val_in[l];
         end
      end
   end

   assign vld_o  = vld_ff;
   assign val_o  = val_ff;
   assign sing_o = sing_ff;
   assign sat_o  = sat_ff;

endmodule

`default_nettype wire

[rtl/affine_2d_inverse.sv]
// Top level of the pipelined 2D affine transform inverter.
`default_nettype none

// Inverts one 2D affine transform (2x2 linear part plus translation, signed
// fixed point with FRAC_BITS fraction bits) per transaction. A new transform
// is taken every clock cycle while the output is not stalled. The pipeline
// has four front stages (input register, six products, determinant and
// numerator magnitudes, divider set-up), one restoring division step per
// quotient bit, and the output register. The divider resolves one bit of
// all six quotients per stage. The whole pipeline advances together whenever
// the output register is empty or being drained, so req_chan.ready drops only
// while a finished result is held back by the sink. Quotients truncate toward
// zero and clamp to the signed word range (saturated = 1); a zero determinant
// gives all-zero values with singular = 1.

module affine_2d_inverse
   import a2i_pkg::*;
#(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic  clock,
   input  wire logic  reset,
   a2i_req_intf.sink   req_chan,
   a2i_rsp_intf.source rsp_chan
);

   localparam int W  = DATA_WIDTH;
   localparam int DW = 2 * W;
   // numerator width: the larger of the linear and the translation numerators
   localparam int NW = (W + 2 * FRAC_BITS > 2 * W + FRAC_BITS) ?
                       W + 2 * FRAC_BITS : 2 * W + FRAC_BITS;

   logic          adv;
   a2i_ctl_type   ctl_c [W+1];
   logic [DW-1:0] den_c [W+1];
   logic [DW-1:0] rem_c [W+1][NLANE];
   logic [W-1:0]  low_c [W+1][NLANE];
   logic [W-1:0]  q_c   [W+1][NLANE];
   logic [W-1:0]  val   [NLANE];
   logic          vld_out, sing_out, sat_out;

   // global advance: stalls only with a held result at the output
   assign adv            = ~vld_out | rsp_chan.ready;
   assign req_chan.ready = adv;

   a2i_front #(
      .DATA_WIDTH (W),
      .FRAC_BITS  (FRAC_BITS),
      .DW         (DW),
      .NW         (NW)
   ) u_front (
      .clock (clock),
      .reset (reset),
      .en    (adv),
      .vld_i (req_chan.valid),
      .xx_i  (req_chan.in_xx),
      .xy_i  (req_chan.in_xy),
      .yx_i  (req_chan.in_yx),
      .yy_i  (req_chan.in_yy),
      .ox_i  (req_chan.in_ox),
      .oy_i  (req_chan.in_oy),
      .ctl_o (ctl_c[0]),
      .den_o (den_c[0]),
      .rem_o (rem_c[0]),
      .low_o (low_c[0])
   );

   // quotient shift registers start empty
   always_comb begin
      for (int l = 0; l < NLANE; l++) begin
         q_c[0][l] = '0;
      end
   end

   for (genvar k = 0; k < W; k++) begin : g_div
      a2i_div_step #(
         .DATA_WIDTH (W),
         .DW         (DW)
      ) u_step (
         .clock (clock),
         .reset (reset),
         .en    (adv),
         .ctl_i (ctl_c[k]),
         .den_i (den_c[k]),
         .rem_i (rem_c[k]),
         .low_i (low_c[k]),
         .q_i   (q_c[k]),
         .ctl_o (ctl_c[k+1]),
         .den_o (den_c[k+1]),
         .rem_o (rem_c[k+1]),
         .low_o (low_c[k+1]),
         .q_o   (q_c[k+1])
      );
   end

   a2i_back #(
      .DATA_WIDTH (W)
   ) u_back (
      .clock  (clock),
      .reset  (reset),
      .en     (adv),
      .ctl_i  (ctl_c[W]),
      .q_i    (q_c[W]),
      .vld_o  (vld_out),
      .val_o  (val),
      .sing_o (sing_out),
      .sat_o  (sat_out)
   );

   assign rsp_chan.valid     = vld_out;
   assign rsp_chan.out_xx    = val[LANE_XX];
   assign rsp_chan.out_xy    = val[LANE_XY];
   assign rsp_chan.out_yx    = val[LANE_YX];
   assign rsp_chan.out_yy    = val[LANE_YY];
   assign rsp_chan.out_ox    = val[LANE_OX];
   assign rsp_chan.out_oy    = val[LANE_OY];
   assign rsp_chan.singular  = sing_out;
   assign rsp_chan.saturated = sat_out;

   // input is refused only behind a stalled result
   a_ready_stall : assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (rsp_chan.valid && !rsp_chan.ready))
      else $error("input refused without output stall");

   // singular result carries zero xx, yy, ox and oy values and no saturation
   a_sing_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.singular) |->
         (!rsp_chan.saturated && rsp_chan.out_xx == '0 && rsp_chan.out_yy == '0 &&
          rsp_chan.out_ox == '0 && rsp_chan.out_oy == '0))
      else $error("singular result not cleared");

   // pipeline moves on once a result is taken
   a_drain : assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready) |-> req_chan.ready)
      else $error("pipeline stalled while output drains");

endmodule

`default_nettype wire
